// ===== sv/frame_power_silence_detector_top_defines.svh =====
// Assertion macros shared by the detector RTL.
`ifndef FRAME_POWER_SILENCE_DETECTOR_TOP_DEFINES_SVH
`define FRAME_POWER_SILENCE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked only outside reset.
`define FPSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked at every edge, reset included.
`define FPSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FPSD_ASSERT(lbl, prop, msg)
`define FPSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/fpsd_pkg.sv =====
`default_nettype none

package fpsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_W      = 32;
    localparam int MAC_W       = 32;
    localparam int PROD_W      = 2 * MAC_W;

    localparam int THR_W  = 31;
    localparam int SIL_W  = 20;
    localparam int RATE_W = 18;
    localparam int CH_W   = 4;
    localparam int CFG_W  = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd3;

    localparam logic [THR_W-1:0]  THR_RESET  = 31'd33955;
    localparam logic [SIL_W-1:0]  SIL_RESET  = 20'd250;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd8000;
    localparam logic [CH_W-1:0]   CH_RESET   = 4'd1;

    localparam logic [MAC_W-1:0] MS_PER_SEC = 32'd1000;

    typedef enum logic [1:0] {
        BASE_ZERO = 2'd0,
        BASE_ACC  = 2'd1,
        BASE_EXT  = 2'd2
    } t_base;

    typedef struct packed {
        logic  issue;
        t_base base;
        logic  sub;
        logic  hi;
    } t_mac_op;

endpackage

`default_nettype wire

// ===== sv/fpsd_sample_if.sv =====
`default_nettype none

interface fpsd_sample_if
    import fpsd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_frame;

    modport source (output valid, output sample, output end_of_frame, input ready);
    modport sink   (input valid, input sample, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/fpsd_result_if.sv =====
`default_nettype none

interface fpsd_result_if
    import fpsd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              silent;
    logic [TIME_W-1:0] silent_time_ms;

    modport source (output valid, output silent, output silent_time_ms, input ready);
    modport sink   (input valid, input silent, input silent_time_ms, output ready);
endinterface

`default_nettype wire

// ===== sv/frame_power_silence_detector_top.sv =====
// Frame power silence detector.
// Input channel i_smp carries one signed 16-bit sample per request, with
// end_of_frame on the last sample of a frame. Output channel o_res carries one
// result per frame: the silent flag and the accumulated silent milliseconds.
// Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_wdata): 0 power
// threshold, 1 silence ms, 2 sample rate, 3 channel count. Any write clears
// the silence timer; write only while the block is idle.
// A sample is accepted, then squared, accumulated and updated on the
// shared 32x32 multiply-accumulate unit. A frame end adds 10 steps (products
// on that unit, then the divider start and the compare), the iterative divider
// for the millisecond conversion and an update step.
// A result sits in an output register; the next frame's samples are accepted
// while it waits, and the block holds at its next frame end until the
// receiver takes it. Synchronous reset restores the register defaults, clears
// the accumulators and the timer, and drops o_res.valid.
`default_nettype none
`include "frame_power_silence_detector_top_defines.svh"

module frame_power_silence_detector_top
    import fpsd_pkg::*;
#(
    parameter int MAX_FRAME = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fpsd_sample_if.sink          i_smp,
    fpsd_result_if.source        o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = CNT_W + SAMPLE_BITS;
    localparam int SQ_W   = CNT_W + 2 * SAMPLE_BITS - 2;
    localparam int NN_W   = 2 * CNT_W;
    localparam int NUM_W  = CNT_W + 10;
    localparam int DEN_W  = RATE_W + CH_W;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_NQ_LO  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_NQ_HI  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SS     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_NN     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ONE_K  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RC     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LIM_LO = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LIM_HI = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIV    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CMP    = 4'd9;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_SQW   = 7'b0000100,
        S_SQU   = 7'b0001000,
        S_FRAME = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_UPD   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [THR_W-1:0]  r_thr;
    logic [SIL_W-1:0]  r_sil;
    logic [RATE_W-1:0] r_rate;
    logic [CH_W-1:0]   r_ch;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;
    logic [CNT_W-1:0]              r_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]               r_sq;
    logic [STEP_W-1:0]             r_step;
    logic [PROD_W-1:0]             r_var;
    logic [NN_W-1:0]               r_nn;
    logic [NUM_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_den;
    logic                          r_loud;
    logic [TIME_W-1:0]             r_timer;
    logic                          r_out_valid;
    logic                          r_out_silent;
    logic [TIME_W-1:0]             r_out_time;

    t_mac_op           mac_op;
    logic [MAC_W-1:0]  mac_a;
    logic [MAC_W-1:0]  mac_b;
    logic [PROD_W-1:0] mac_ext;
    logic [PROD_W-1:0] mac_acc;

    logic             div_start;
    logic             div_busy;
    logic [NUM_W-1:0] div_quot;

    logic signed [SAMPLE_BITS:0] x_wide;
    logic [SAMPLE_BITS:0]        x_mag;
    logic [SUM_W-1:0]            s_mag;
    logic [PROD_W-1:0]           sq_wide;
    logic [PROD_W-1:0]           nn_wide;
    logic [MAC_W-1:0]            n32;
    logic [RATE_W-1:0]           rate_eff;
    logic [CH_W-1:0]             ch_eff;
    logic                        cfg_hit;
    logic                        out_free;
    logic                        room;
    logic [TIME_W:0]             t_sum;
    logic [TIME_W-1:0]           t_next;

    fpsd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_ext   (mac_ext),
        .o_acc   (mac_acc)
    );

    fpsd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign i_smp.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.silent         = r_out_silent;
    assign o_res.silent_time_ms = r_out_time;

    always_comb begin
        x_wide   = (SAMPLE_BITS + 1)'(r_x);
        x_mag    = x_wide[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-x_wide) : x_wide;
        s_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        sq_wide  = PROD_W'(r_sq);
        nn_wide  = PROD_W'(r_nn);
        n32      = MAC_W'(r_count);
        rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;
        ch_eff   = (r_ch == '0) ? CH_W'(1) : r_ch;
        cfg_hit  = i_cfg_we;
        out_free = !r_out_valid || o_res.ready;
        room     = (r_count < CNT_W'(MAX_FRAME));
        t_sum    = {1'b0, r_timer} + (TIME_W + 1)'(div_quot);
        if (r_loud) begin
            t_next = '0;
        end else if (t_sum[TIME_W]) begin
            t_next = '1;
        end else begin
            t_next = t_sum[TIME_W-1:0];
        end
        div_start = (r_state == S_FRAME) && (r_step == STEP_DIV);
    end

    // drive the shared multiply-accumulate unit
    always_comb begin
        mac_op  = '0;
        mac_a   = '0;
        mac_b   = '0;
        mac_ext = sq_wide;
        if (r_state == S_SQ) begin
            mac_op.issue = 1'b1;
            mac_op.base  = BASE_EXT;
            mac_a        = MAC_W'(x_mag);
            mac_b        = MAC_W'(x_mag);
        end else if (r_state == S_FRAME) begin
            case (r_step)
                STEP_NQ_LO: begin
                    mac_op.issue = 1'b1;
                    mac_a        = n32;
                    mac_b        = sq_wide[MAC_W-1:0];
                end
                STEP_NQ_HI: begin
                    mac_op.issue = 1'b1;
                    mac_op.base  = BASE_ACC;
                    mac_op.hi    = 1'b1;
                    mac_a        = n32;
                    mac_b        = sq_wide[PROD_W-1:MAC_W];
                end
                STEP_SS: begin
                    mac_op.issue = 1'b1;
                    mac_op.base  = BASE_ACC;
                    mac_op.sub   = 1'b1;
                    mac_a        = MAC_W'(s_mag);
                    mac_b        = MAC_W'(s_mag);
                end
                STEP_NN: begin
                    mac_op.issue = 1'b1;
                    mac_a        = n32;
                    mac_b        = n32;
                end
                STEP_ONE_K: begin
                    mac_op.issue = 1'b1;
                    mac_a        = n32;
                    mac_b        = MS_PER_SEC;
                end
                STEP_RC: begin
                    mac_op.issue = 1'b1;
                    mac_a        = MAC_W'(rate_eff);
                    mac_b        = MAC_W'(ch_eff);
                end
                STEP_LIM_LO: begin
                    mac_op.issue = 1'b1;
                    mac_a        = MAC_W'(r_thr);
                    mac_b        = nn_wide[MAC_W-1:0];
                end
                STEP_LIM_HI: begin
                    mac_op.issue = 1'b1;
                    mac_op.base  = BASE_ACC;
                    mac_op.hi    = 1'b1;
                    mac_a        = MAC_W'(r_thr);
                    mac_b        = nn_wide[PROD_W-1:MAC_W];
                end
                default: begin
                    mac_op = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    if (room) begin
                        n_state = S_SQ;
                    end else if (i_smp.end_of_frame) begin
                        n_state = S_FRAME;
                    end
                end
            end
            S_SQ:    n_state = S_SQW;
            S_SQW:   n_state = S_SQU;
            S_SQU:   n_state = r_last ? S_FRAME : S_IDLE;
            S_FRAME: n_state = (r_step == STEP_CMP) ? S_DIV : S_FRAME;
            S_DIV:   n_state = div_busy ? S_DIV : S_UPD;
            S_UPD:   n_state = out_free ? S_IDLE : S_UPD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_sil       <= SIL_RESET;
            r_rate      <= RATE_RESET;
            r_ch        <= CH_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == S_FRAME) ? r_step + 1'b1 : '0;

            if (r_state == S_SQU) begin
                r_sq    <= mac_acc[SQ_W-1:0];
                r_sum   <= r_sum + SUM_W'(r_x);
                r_count <= r_count + 1'b1;
            end

            if (cfg_hit) begin
                r_timer <= '0;
                case (i_cfg_idx)
                    CFG_POWER_THRESHOLD: r_thr  <= i_cfg_wdata[THR_W-1:0];
                    CFG_SILENCE_MS:      r_sil  <= i_cfg_wdata[SIL_W-1:0];
                    CFG_SAMPLE_RATE:     r_rate <= i_cfg_wdata[RATE_W-1:0];
                    CFG_CHANNEL_COUNT:   r_ch   <= i_cfg_wdata[CH_W-1:0];
                    default:             ;
                endcase
            end else if ((r_state == S_UPD) && out_free) begin
                r_timer <= t_next;
            end

            // result loads as the frame closes; drop it once taken
            if ((r_state == S_UPD) && out_free) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum       <= '0;
                r_sq        <= '0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_smp.valid) begin
            r_x    <= i_smp.sample;
            r_last <= i_smp.end_of_frame;
        end
        if (r_state == S_FRAME) begin
            case (r_step)
                STEP_ONE_K:  r_var  <= mac_acc;
                STEP_RC:     r_nn   <= mac_acc[NN_W-1:0];
                STEP_LIM_LO: r_num  <= mac_acc[NUM_W-1:0];
                STEP_LIM_HI: r_den  <= mac_acc[DEN_W-1:0];
                STEP_CMP:    r_loud <= (r_var > mac_acc);
                default:     r_loud <= r_loud;
            endcase
        end
        if ((r_state == S_UPD) && out_free) begin
            r_out_silent <= (t_next >= TIME_W'(r_sil));
            r_out_time   <= t_next;
        end
    end

    `FPSD_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_FRAME), "sample count beyond MAX_FRAME")
    `FPSD_ASSERT(a_var_nonneg, (r_state == S_FRAME) && (r_step == STEP_ONE_K) |-> !mac_acc[PROD_W-1], "frame variance negative")
    `FPSD_ASSERT(a_div_idle_start, div_start |-> !div_busy, "divider restarted while busy")
    `FPSD_ASSERT(a_load_to_idle, $rose(r_out_valid) |-> (r_state == S_IDLE), "result loaded outside frame close")
    `FPSD_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid, "reset left block busy")

endmodule

`default_nettype wire

// ===== sv/fpsd_mac.sv =====
`default_nettype none

module fpsd_mac
    import fpsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_op           i_op,
    input  logic [MAC_W-1:0]  i_a,
    input  logic [MAC_W-1:0]  i_b,
    input  logic [PROD_W-1:0] i_ext,
    output logic [PROD_W-1:0] o_acc
);

    t_mac_op           r_op;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_ext;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] shifted;
    logic [PROD_W-1:0] base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_ext  <= i_ext;
        if (r_op.issue) begin
            r_acc <= r_op.sub ? (base - shifted) : (base + shifted);
        end
    end

    always_comb begin
        shifted = r_op.hi ? {r_prod[MAC_W-1:0], {MAC_W{1'b0}}} : r_prod;
        case (r_op.base)
            BASE_ACC: base = r_acc;
            BASE_EXT: base = r_ext;
            default:  base = '0;
        endcase
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== sv/fpsd_div.sv =====
`default_nettype none

module fpsd_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // while busy, shift one numerator bit into the remainder and one quotient bit into r_quot per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[NUM_W-2:0], fits};
            r_rem  <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

`default_nettype wire
